[sv/lpip_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the lidar point to image projection block.
package lpip_pkg;

  // Width of the projected sums u, v, w (Q32.16 plus headroom)
  localparam int AccW = 50;
  // Quotient bits resolved by the divider; larger quotients are flagged as overflow
  localparam int QuoW = 18;
  localparam int PixW = 16;

  typedef logic [2:0][3:0][31:0] coef_mat_t;

  typedef enum logic [2:0] {
    REG_ROW0_A      = 3'd0,
    REG_ROW0_B      = 3'd1,
    REG_ROW1_A      = 3'd2,
    REG_ROW1_B      = 3'd3,
    REG_ROW2_A      = 3'd4,
    REG_ROW2_B      = 3'd5,
    REG_IMAGE_SIZE  = 3'd6,
    REG_EDGE_MARGIN = 3'd7
  } reg_idx_t;

  // Divider stage contents, also handed to the rounding stage
  typedef struct packed {
    logic            wpos;
    logic            neg_u;
    logic            neg_v;
    logic            ovf_u;
    logic            ovf_v;
    logic [QuoW-1:0] q_u;
    logic [QuoW-1:0] q_v;
    logic [AccW-1:0] rem_u;
    logic [AccW-1:0] rem_v;
    logic [AccW-1:0] den;
  } div_res_t;

endpackage

[sv/lpip_mac.sv]
`timescale 1ns / 1ps
// Matrix-vector product: nine products, then a two-level registered adder tree.
module lpip_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                ce,
  input  logic                                in_valid,
  input  logic signed [31:0]                  px,
  input  logic signed [31:0]                  py,
  input  logic signed [31:0]                  pz,
  input  lpip_pkg::coef_mat_t                 coef,
  output logic                                acc_valid,
  output logic signed [lpip_pkg::AccW-1:0]    u,
  output logic signed [lpip_pkg::AccW-1:0]    v,
  output logic signed [lpip_pkg::AccW-1:0]    w
);

  logic signed [31:0]                 pt [3];
  logic signed [63:0]                 prod [3][3];
  logic signed [lpip_pkg::AccW-1:0]   s01 [3];
  logic signed [lpip_pkg::AccW-1:0]   s2c [3];
  logic signed [lpip_pkg::AccW-1:0]   acc [3];
  logic                               vld1;
  logic                               vld2;

  assign pt[0] = px;
  assign pt[1] = py;
  assign pt[2] = pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      acc_valid <= 1'b0;
    end else if (ce) begin
      vld1      <= in_valid;
      vld2      <= vld1;
      acc_valid <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed(coef[r][c]) * pt[c];
        end
        // floor shift by 16: drop the low bits of the two's complement product
        s01[r] <= lpip_pkg::AccW'($signed(prod[r][0][63:16]))
                + lpip_pkg::AccW'($signed(prod[r][1][63:16]));
        s2c[r] <= lpip_pkg::AccW'($signed(prod[r][2][63:16]))
                + lpip_pkg::AccW'($signed(coef[r][3]));
        acc[r] <= s01[r] + s2c[r];
      end
    end
  end

  assign u = acc[0];
  assign v = acc[1];
  assign w = acc[2];

endmodule

[sv/lpip_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider: u / w and v / w, one quotient bit per stage.
module lpip_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              ce,
  input  logic                              in_valid,
  input  logic signed [lpip_pkg::AccW-1:0]  u,
  input  logic signed [lpip_pkg::AccW-1:0]  v,
  input  logic signed [lpip_pkg::AccW-1:0]  w,
  output logic                              res_valid,
  output lpip_pkg::div_res_t                res
);

  localparam int AW = lpip_pkg::AccW;
  localparam int QW = lpip_pkg::QuoW;
  localparam int XW = AW + QW;

  lpip_pkg::div_res_t st  [QW+1];
  logic               vld [QW+1];

  // Entry stage: magnitudes, signs, depth test
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      st[0].wpos  <= !w[AW-1] && (|w);
      st[0].neg_u <= u[AW-1];
      st[0].neg_v <= v[AW-1];
      st[0].ovf_u <= 1'b0;
      st[0].ovf_v <= 1'b0;
      st[0].q_u   <= '0;
      st[0].q_v   <= '0;
      st[0].rem_u <= u[AW-1] ? AW'(-u) : AW'(u);
      st[0].rem_v <= v[AW-1] ? AW'(-v) : AW'(v);
      st[0].den   <= AW'(w);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int Bit = QW - 1 - k;
    logic [XW-1:0]      sh_d;
    logic               ge_u;
    logic               ge_v;
    lpip_pkg::div_res_t nxt;

    assign sh_d = XW'(st[k].den) << Bit;
    assign ge_u = XW'(st[k].rem_u) >= sh_d;
    assign ge_v = XW'(st[k].rem_v) >= sh_d;

    always_comb begin
      nxt = st[k];
      nxt.q_u[Bit] = ge_u;
      nxt.q_v[Bit] = ge_v;
      if (ge_u) begin
        nxt.rem_u = st[k].rem_u - sh_d[AW-1:0];
      end
      if (ge_v) begin
        nxt.rem_v = st[k].rem_v - sh_d[AW-1:0];
      end
      // quotient too large to resolve: flag it in the first step
      if (k == 0) begin
        nxt.ovf_u = XW'(st[k].rem_u) >= {st[k].den, QW'(0)};
        nxt.ovf_v = XW'(st[k].rem_v) >= {st[k].den, QW'(0)};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ce) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        st[k+1] <= nxt;
      end
    end
  end

  assign res_valid = vld[QW];
  assign res       = st[QW];

endmodule

[sv/lpip_fin.sv]
`timescale 1ns / 1ps
// Round to nearest even, saturate, bounds test, and the output register.
module lpip_fin (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           ce,
  input  logic                           res_valid,
  input  lpip_pkg::div_res_t             res,
  input  logic [31:0]                    img_size,
  input  logic [11:0]                    margin,
  output logic                           out_valid,
  output logic [lpip_pkg::PixW-1:0]      col,
  output logic [lpip_pkg::PixW-1:0]      row,
  output logic                           vis
);

  localparam int QW = lpip_pkg::QuoW;
  localparam int SW = QW + 2;
  localparam int PW = lpip_pkg::PixW;
  localparam logic signed [SW-1:0] PixMax = SW'((1 << (PW - 1)) - 1);
  localparam logic signed [SW-1:0] PixMin = -SW'(1 << (PW - 1));
  localparam logic [PW-1:0]        SatHi  = PW'((1 << (PW - 1)) - 1);
  localparam logic [PW-1:0]        SatLo  = PW'(1 << (PW - 1));

  logic            up_u;
  logic            up_v;
  logic            r_valid;
  logic            r_wpos;
  logic            r_neg_u;
  logic            r_neg_v;
  logic            r_ovf_u;
  logic            r_ovf_v;
  logic [QW:0]     r_q_u;
  logic [QW:0]     r_q_v;

  logic signed [SW-1:0] cu;
  logic signed [SW-1:0] cv;
  logic signed [SW-1:0] lo_b;
  logic signed [SW-1:0] hi_w;
  logic signed [SW-1:0] hi_h;
  logic                 in_u;
  logic                 in_v;
  logic [PW-1:0]        col_next;
  logic [PW-1:0]        row_next;
  logic                 vis_next;

  // round up when twice the remainder passes the divisor, ties to even
  assign up_u = ({res.rem_u, 1'b0} > {1'b0, res.den})
             || (({res.rem_u, 1'b0} == {1'b0, res.den}) && res.q_u[0]);
  assign up_v = ({res.rem_v, 1'b0} > {1'b0, res.den})
             || (({res.rem_v, 1'b0} == {1'b0, res.den}) && res.q_v[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      r_valid   <= res_valid;
      out_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      r_wpos  <= res.wpos;
      r_neg_u <= res.neg_u;
      r_neg_v <= res.neg_v;
      r_ovf_u <= res.ovf_u;
      r_ovf_v <= res.ovf_v;
      r_q_u   <= (QW+1)'(res.q_u) + (QW+1)'(up_u);
      r_q_v   <= (QW+1)'(res.q_v) + (QW+1)'(up_v);
    end
  end

  always_comb begin
    cu   = r_neg_u ? -$signed({1'b0, r_q_u}) : $signed({1'b0, r_q_u});
    cv   = r_neg_v ? -$signed({1'b0, r_q_v}) : $signed({1'b0, r_q_v});
    lo_b = -$signed(SW'(margin));
    hi_w = $signed(SW'(img_size[15:0]) + SW'(margin));
    hi_h = $signed(SW'(img_size[31:16]) + SW'(margin));
    in_u = !r_ovf_u && (cu >= lo_b) && (cu < hi_w);
    in_v = !r_ovf_v && (cv >= lo_b) && (cv < hi_h);

    if (r_ovf_u) begin
      col_next = r_neg_u ? SatLo : SatHi;
    end else if (cu > PixMax) begin
      col_next = SatHi;
    end else if (cu < PixMin) begin
      col_next = SatLo;
    end else begin
      col_next = cu[PW-1:0];
    end

    if (r_ovf_v) begin
      row_next = r_neg_v ? SatLo : SatHi;
    end else if (cv > PixMax) begin
      row_next = SatHi;
    end else if (cv < PixMin) begin
      row_next = SatLo;
    end else begin
      row_next = cv[PW-1:0];
    end

    vis_next = in_u && in_v;

    // depth not positive: report a miss at pixel zero
    if (!r_wpos) begin
      col_next = '0;
      row_next = '0;
      vis_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      col <= col_next;
      row <= row_next;
      vis <= vis_next;
    end
  end

endmodule

[sv/lidar_point_image_projection.sv]
`timescale 1ns / 1ps
// Pipeline from input beat to output beat: 3 multiply/add stages,
// 1 setup stage, 18 divider stages, rounding, output register.
// Throughput: one point per cycle; the whole pipeline holds while an output
// beat waits for m_tready.
// Reset: synchronous rst clears all valid bits and sets every configuration register to zero.
module lidar_point_image_projection (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // point_x, point_y, point_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel_col, pixel_row
  output logic        m_tuser    // in_view
);

  lpip_pkg::coef_mat_t coef;
  logic [31:0]         img_size;
  logic [11:0]         margin;
  logic                ce;

  logic                               acc_valid;
  logic signed [lpip_pkg::AccW-1:0]   u;
  logic signed [lpip_pkg::AccW-1:0]   v;
  logic signed [lpip_pkg::AccW-1:0]   w;
  logic                               res_valid;
  lpip_pkg::div_res_t                 res;
  logic [lpip_pkg::PixW-1:0]          col;
  logic [lpip_pkg::PixW-1:0]          row;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef     <= '0;
      img_size <= '0;
      margin   <= '0;
    end else if (cfg_we) begin
      case (lpip_pkg::reg_idx_t'(cfg_index))
        lpip_pkg::REG_ROW0_A, lpip_pkg::REG_ROW0_B,
        lpip_pkg::REG_ROW1_A, lpip_pkg::REG_ROW1_B,
        lpip_pkg::REG_ROW2_A, lpip_pkg::REG_ROW2_B: begin
          coef[cfg_index[2:1]][{cfg_index[0], 1'b0}] <= cfg_data[31:0];
          coef[cfg_index[2:1]][{cfg_index[0], 1'b1}] <= cfg_data[63:32];
        end
        lpip_pkg::REG_IMAGE_SIZE: begin
          img_size <= cfg_data[31:0];
        end
        lpip_pkg::REG_EDGE_MARGIN: begin
          margin <= cfg_data[11:0];
        end
        default: ;
      endcase
    end
  end

  // advance every stage unless a finished beat is held at the output
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  lpip_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .px        ($signed(s_tdata[31:0])),
    .py        ($signed(s_tdata[63:32])),
    .pz        ($signed(s_tdata[95:64])),
    .coef      (coef),
    .acc_valid (acc_valid),
    .u         (u),
    .v         (v),
    .w         (w)
  );

  lpip_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (acc_valid),
    .u         (u),
    .v         (v),
    .w         (w),
    .res_valid (res_valid),
    .res       (res)
  );

  lpip_fin u_fin (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .res_valid (res_valid),
    .res       (res),
    .img_size  (img_size),
    .margin    (margin),
    .out_valid (m_tvalid),
    .col       (col),
    .row       (row),
    .vis       (m_tuser)
  );

  assign m_tdata = {row, col};

endmodule
